[sv/hpa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hpa_pkg
// Shared types and constants of the handle pool allocator.
// ----------------------------------------------------------------------------
package hpa_pkg;

  localparam int unsigned HandleW          = 8;
  localparam int unsigned HandleSpace      = 1 << HandleW;
  localparam int unsigned CountW           = HandleW + 1;
  localparam int unsigned PoolSizeDefault  = 256;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_TRY     = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_INVALID   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

endpackage
`default_nettype wire

[sv/handle_pool_allocator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// handle_pool_allocator_top
// Object handle pool with a FIFO free list kept in a synchronous memory.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Word
//  --------+-----------+------------------------+--------------------------
//  in      | input     | in_valid_i / in_stall_o   | operation_i, handle_in_i
//  out     | output    | out_valid_o / out_stall_i | handle_out_o, status_o
//
// Each request is taken in the idle state, which also issues the reads of
// the free-list memory and the allocated bitmap memory; in the execute state
// it decides, writes back and loads the result register. A new word is
// accepted only in idle, so not until the previous request has finished.
// A result waiting in the output register does not block the next request;
// only a second result that finds the register still stalled waits there.
// Reset clears the state, counters, pointers and output valid only. The bitmap
// memory needs no clearing pass: a handle at or above the creation count is never
// allocated, and every entry below it was written when that handle was made.
//
module handle_pool_allocator_top #(
  parameter int unsigned POOL_SIZE = hpa_pkg::PoolSizeDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  operation_i,
  input  wire logic [hpa_pkg::HandleW-1:0] handle_in_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [hpa_pkg::HandleW-1:0]      handle_out_o,
  output logic [1:0]                       status_o
);

  localparam int unsigned HW = hpa_pkg::HandleW;
  localparam int unsigned CW = hpa_pkg::CountW;
  // Handles are HW bits wide, so no more than HandleSpace can ever exist.
  localparam int unsigned Limit =
    (POOL_SIZE < hpa_pkg::HandleSpace) ? POOL_SIZE : hpa_pkg::HandleSpace;
  localparam logic [CW-1:0] LimitC = CW'(Limit);

  // Storage: the free list ring and the allocated bitmap.
  logic [HW-1:0] fq_mem  [hpa_pkg::HandleSpace];
  logic          map_mem [hpa_pkg::HandleSpace];

  hpa_pkg::state_e state_q, state_d;
  logic [HW-1:0]   head_q, head_d;
  logic [HW-1:0]   tail_q, tail_d;
  logic [CW-1:0]   free_count_q, free_count_d;
  logic [CW-1:0]   created_q, created_d;

  hpa_pkg::op_e    op_q;
  logic [HW-1:0]   hin_q;
  logic [HW-1:0]   fq_rdata_q;
  logic            map_rdata_q;

  logic            out_valid_q, out_valid_d;
  logic [HW-1:0]   out_handle_q, out_handle_d;
  hpa_pkg::status_e out_status_q, out_status_d;

  logic            in_fire;
  logic            exec_fire;
  logic            map_we;
  logic [HW-1:0]   map_waddr;
  logic            map_wdata;
  logic            fq_we;
  logic            rel_ok;

  assign in_stall_o = (state_q != hpa_pkg::S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  // The result register must be free, or about to be emptied, to finish.
  assign exec_fire  = (state_q == hpa_pkg::S_EXEC) && !(out_valid_q && out_stall_i);

  // A release is legal only for a handle already created whose bit is set.
  assign rel_ok = ({1'b0, hin_q} < created_q) && map_rdata_q;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    free_count_d = free_count_q;
    created_d    = created_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_handle_d = out_handle_q;
    out_status_d = out_status_q;
    map_we       = 1'b0;
    map_waddr    = hin_q;
    map_wdata    = 1'b0;
    fq_we        = 1'b0;

    case (state_q)
      hpa_pkg::S_IDLE: begin
        if (in_fire) begin
          state_d = hpa_pkg::S_EXEC;
        end
      end
      hpa_pkg::S_EXEC: begin
        if (exec_fire) begin
          state_d      = hpa_pkg::S_IDLE;
          out_valid_d  = 1'b1;
          out_handle_d = '0;
          out_status_d = hpa_pkg::ST_OK;
          case (op_q)
            hpa_pkg::OP_ALLOC, hpa_pkg::OP_TRY: begin
              if (free_count_q != '0) begin
                // Oldest released handle comes off the head of the ring.
                out_handle_d = fq_rdata_q;
                map_we       = 1'b1;
                map_waddr    = fq_rdata_q;
                map_wdata    = 1'b1;
                head_d       = head_q + 1'b1;
                free_count_d = free_count_q - 1'b1;
              end else if (op_q == hpa_pkg::OP_TRY) begin
                out_status_d = hpa_pkg::ST_NONE_FREE;
              end else if (created_q < LimitC) begin
                out_handle_d = created_q[HW-1:0];
                map_we       = 1'b1;
                map_waddr    = created_q[HW-1:0];
                map_wdata    = 1'b1;
                created_d    = created_q + 1'b1;
              end else begin
                out_status_d = hpa_pkg::ST_EXHAUSTED;
              end
            end
            hpa_pkg::OP_RELEASE: begin
              if (rel_ok) begin
                map_we       = 1'b1;
                map_waddr    = hin_q;
                map_wdata    = 1'b0;
                fq_we        = 1'b1;
                tail_d       = tail_q + 1'b1;
                free_count_d = free_count_q + 1'b1;
              end else begin
                out_status_d = hpa_pkg::ST_INVALID;
              end
            end
            default: begin
              // No operation: report ok with no handle.
            end
          endcase
        end
      end
      default: begin
        state_d = hpa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= hpa_pkg::S_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      free_count_q <= '0;
      created_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      free_count_q <= free_count_d;
      created_q    <= created_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= hpa_pkg::op_e'(operation_i);
      hin_q <= handle_in_i;
    end
    out_handle_q <= out_handle_d;
    out_status_q <= out_status_d;
  end

  // Free list memory: read the head when a request is taken, write the tail
  // on a good release.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fq_rdata_q <= fq_mem[head_q];
    end
    if (fq_we) begin
      fq_mem[tail_q] <= hin_q;
    end
  end

  // Bitmap memory: read the handle named by the request, write on commit.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      map_rdata_q <= map_mem[handle_in_i];
    end
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign handle_out_o = out_handle_q;
  assign status_o     = out_status_q;

  // Free handles are a subset of created handles.
  a_free_le_created: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_count_q <= created_q)
    else $error("free count exceeds created count");

  a_created_le_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    created_q <= LimitC)
    else $error("creation counter passed the pool limit");

  // Ring pointers stay consistent with the free count.
  a_ring_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    HW'(tail_q - head_q) == free_count_q[HW-1:0])
    else $error("free list pointers disagree with free count");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == hpa_pkg::S_EXEC))
    else $error("accepted request did not start execution");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == hpa_pkg::S_EXEC))
    else $error("result appeared without an executing request");

endmodule
`default_nettype wire
